@@ hdl/mlvp_pkg.sv @@
// shared constants, payload types and request types for the lamp voltage pid
package mlvp_pkg;

    localparam int SOUND_TAPS = 2;
    localparam int DUTY_TOP   = 999;
    localparam int SWEEP_TOP  = 1000;

    localparam int SAMPLE_W  = 12;
    localparam int SLOT_W    = (SOUND_TAPS > 1) ? $clog2(SOUND_TAPS) : 1;
    localparam int SUM_W     = SAMPLE_W + $clog2(SOUND_TAPS);
    localparam int IDX_W     = 16;
    localparam int CFG_W     = 16;
    localparam int MODE_W    = 8;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam int DVD_W     = 36;
    localparam int DSR_W     = 16;
    localparam int DIV_CNT_W = $clog2(DVD_W);
    localparam int VPROD_W   = 31;
    localparam int VOUT_W    = 21;
    localparam int TGT_W     = 24;
    localparam int ERR_W     = TGT_W + 1;
    localparam int ACC_W     = 32;
    localparam int OPD_W     = ACC_W + 1;
    localparam int GAIN_W    = 16;
    localparam int PROD_W    = GAIN_W + OPD_W;
    localparam int PSUM_W    = PROD_W + 2;
    localparam int MUL_CNT_W = $clog2(GAIN_W);
    localparam int DUTY_W    = 10;
    localparam int FRAC_W    = 16;
    localparam int DUTY_SH   = 24;

    localparam logic [18:0]      VOUT_NUM   = 19'd329472;
    localparam logic [DSR_W-1:0] VOUT_DEN   = DSR_W'(1000);
    localparam logic [DSR_W-1:0] MANUAL_DEN = DSR_W'(5000);
    localparam logic [TGT_W-1:0] VOLT_6     = TGT_W'(6 * 65536);
    localparam logic [TGT_W-1:0] VOLT_8     = TGT_W'(8 * 65536);

    // mode codes
    localparam logic [MODE_W-1:0] MODE_LIGHT  = 8'd0;
    localparam logic [MODE_W-1:0] MODE_SOUND  = 8'd1;
    localparam logic [MODE_W-1:0] MODE_MANUAL = 8'd2;
    localparam logic [MODE_W-1:0] MODE_BREATH = 8'd3;
    localparam logic [MODE_W-1:0] MODE_FAST   = 8'd4;
    localparam logic [MODE_W-1:0] MODE_BREATH_ALT = 8'd5;

    localparam logic [CFG_W-1:0] GAIN_P_RST = 16'd12800;
    localparam logic [CFG_W-1:0] GAIN_I_RST = 16'd1280;
    localparam logic [CFG_W-1:0] GAIN_D_RST = 16'd256;
    localparam logic [CFG_W-1:0] ILIMIT_RST = 16'd1000;

    typedef enum logic [2:0] {
        REG_MODE    = 3'd0,
        REG_MANUAL  = 3'd1,
        REG_GAIN_P  = 3'd2,
        REG_GAIN_I  = 3'd3,
        REG_GAIN_D  = 3'd4,
        REG_ILIMIT  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_vout;
        logic [SAMPLE_W-1:0] sample_light;
        logic [SAMPLE_W-1:0] sample_sound;
    } t_in;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [TGT_W-1:0]  target_volts;
    } t_out;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              start;
        logic [GAIN_W-1:0] gain;
        logic [OPD_W-1:0]  operand;
    } t_mul_req;

endpackage

@@ hdl/mlvp_div.sv @@
// restoring divider, one quotient bit per cycle
module mlvp_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  mlvp_pkg::t_div_req       i_req,
    output logic                     o_done,
    output logic [mlvp_pkg::DVD_W-1:0] o_quot
);
    import mlvp_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0]     r_quot;
    logic [DSR_W-1:0]     r_rem;
    logic [DSR_W-1:0]     r_dsr;
    logic [DSR_W:0]       w_trial;
    logic [DSR_W:0]       w_diff;
    logic                 w_ge;

    // dividend bits leave at the top while quotient bits enter at the bottom
    assign w_trial = {r_rem, r_quot[DVD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_dsr  <= i_req.divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[DSR_W-1:0] : w_trial[DSR_W-1:0];
            r_quot <= {r_quot[DVD_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ hdl/mlvp_mul.sv @@
// shift-add multiplier, one gain bit per cycle, signed operand
module mlvp_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mlvp_pkg::t_mul_req          i_req,
    output logic                        o_done,
    output logic [mlvp_pkg::PROD_W-1:0] o_prod
);
    import mlvp_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [GAIN_W-1:0]    r_gain;
    logic [PROD_W-1:0]    r_opd;
    logic [PROD_W-1:0]    r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(GAIN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_gain <= i_req.gain;
            r_opd  <= {{(PROD_W-OPD_W){i_req.operand[OPD_W-1]}}, i_req.operand};
            r_acc  <= '0;
        end else if (r_busy) begin
            r_acc  <= r_acc + (r_gain[0] ? r_opd : '0);
            r_gain <= r_gain >> 1;
            r_opd  <= r_opd << 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ hdl/multimode_lamp_voltage_pid.sv @@
// top level: mode target forming, serial divide and pid, apb registers
//
//  channel  direction  handshake                   payload
//  in       sink       i_in_valid / o_in_ready     i_in  (vout, light, sound)
//  out      source     o_out_valid / i_out_ready   o_out (duty, target_volts)
//  cfg      apb slave  psel penable pwrite pready  paddr pwdata prdata
//
// one item at a time; from transfer in to result shown it passes prepare, two runs
// of the serial divider (voltage scaling, then target; the target run is skipped when a
// light or sound map has a zero range), pid update, three runs of the serial multiplier
// (p, i, d), then the load of the result register
// reset is synchronous and clears all tracking, sweep and pid state
// the next item is taken while a result still waits in the output register;
// a held result stalls only the finishing step of the following item
module multimode_lamp_voltage_pid (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  mlvp_pkg::t_in                 i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output mlvp_pkg::t_out                o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mlvp_pkg::ADDR_W-1:0]   paddr,
    input  logic [mlvp_pkg::DATA_W-1:0]   pwdata,
    output logic [mlvp_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import mlvp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PREP = 7'b0000010,
        S_VDIV = 7'b0000100,
        S_TDIV = 7'b0001000,
        S_PID  = 7'b0010000,
        S_MUL  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    typedef enum logic [1:0] {
        TERM_P = 2'd0,
        TERM_I = 2'd1,
        TERM_D = 2'd2
    } t_term;

    function automatic logic [DVD_W-1:0] map_dvd(input logic [IDX_W-1:0] x,
                                                  input logic [3:0] k);
        logic [IDX_W+3:0] p;
        p = (IDX_W+4)'(x) * (IDX_W+4)'(k);
        return DVD_W'({p, {FRAC_W{1'b0}}});
    endfunction

    // configuration registers
    logic [MODE_W-1:0] r_mode;
    logic [CFG_W-1:0]  r_manual;
    logic [CFG_W-1:0]  r_gain_p;
    logic [CFG_W-1:0]  r_gain_i;
    logic [CFG_W-1:0]  r_gain_d;
    logic [CFG_W-1:0]  r_ilimit;
    t_reg_idx          w_reg;
    logic              w_wr;

    // tracking and pid state
    logic                r_light_seen;
    logic [SAMPLE_W-1:0] r_light_high;
    logic [SAMPLE_W-1:0] r_light_low;
    logic [SAMPLE_W-1:0] r_taps [SOUND_TAPS];
    logic [SLOT_W-1:0]   r_slot;
    logic                r_sound_seen;
    logic [SUM_W-1:0]    r_sound_high;
    logic [SUM_W-1:0]    r_sound_low;
    logic [IDX_W-1:0]    r_sweep;
    logic                r_slow_down;
    logic                r_fast_down;
    logic signed [ERR_W-1:0] r_prev_err;
    logic signed [ACC_W-1:0] r_accum;

    // per item registers
    t_state              r_state;
    t_in                 r_in;
    logic [DVD_W-1:0]    r_tgt_dvd;
    logic [DSR_W-1:0]    r_tgt_dsr;
    logic [TGT_W-1:0]    r_tgt_base;
    logic                r_tgt_skip;
    logic [VOUT_W-1:0]   r_vout;
    logic [TGT_W-1:0]    r_target;
    logic signed [ACC_W-1:0]   r_integ;
    logic signed [ERR_W:0]     r_deriv;
    t_term               r_term;
    logic signed [PSUM_W-1:0]  r_psum;
    t_out                r_out;
    logic                r_out_valid;

    // prepare step logic
    logic [SAMPLE_W-1:0] w_l_hi, w_l_lo;
    logic [SLOT_W-1:0]   w_slot, w_slot_nx;
    logic [SAMPLE_W-1:0] w_taps [SOUND_TAPS];
    logic [SUM_W-1:0]    w_sum, w_s_hi, w_s_lo;
    logic [IDX_W-1:0]    w_step, w_sw_n, w_sw_idx;
    logic                w_down, w_sw_top, w_sw_flip;
    logic [IDX_W-1:0]    w_map_x;
    logic [3:0]          w_map_k;
    logic [DSR_W-1:0]    w_map_dsr;
    logic [TGT_W-1:0]    w_map_base;
    logic                w_map_skip;
    logic [VPROD_W-1:0]  w_vprod;

    // pid logic
    logic signed [ERR_W-1:0] w_err;
    logic signed [OPD_W-1:0] w_lim, w_isum, w_iclamp;
    logic signed [ACC_W-1:0] w_integ;
    logic signed [ERR_W:0]   w_deriv;
    logic                    w_out_free;
    logic [DUTY_W-1:0]       w_duty;

    t_div_req          w_div_req;
    logic              w_div_done;
    logic [DVD_W-1:0]  w_quot;
    t_mul_req          w_mul_req;
    logic              w_mul_done;
    logic [PROD_W-1:0] w_prod;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_reg  = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_LIGHT;
            r_manual <= '0;
            r_gain_p <= GAIN_P_RST;
            r_gain_i <= GAIN_I_RST;
            r_gain_d <= GAIN_D_RST;
            r_ilimit <= ILIMIT_RST;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_MODE: begin
                    r_mode <= pwdata[MODE_W-1:0];
                    // modes past the table drop the manual level
                    if (pwdata[MODE_W-1:0] > MODE_BREATH_ALT) begin
                        r_manual <= '0;
                    end
                end
                REG_MANUAL: r_manual <= pwdata[CFG_W-1:0];
                REG_GAIN_P: r_gain_p <= pwdata[CFG_W-1:0];
                REG_GAIN_I: r_gain_i <= pwdata[CFG_W-1:0];
                REG_GAIN_D: r_gain_d <= pwdata[CFG_W-1:0];
                REG_ILIMIT: r_ilimit <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_MODE:   prdata = DATA_W'(r_mode);
            REG_MANUAL: prdata = DATA_W'(r_manual);
            REG_GAIN_P: prdata = DATA_W'(r_gain_p);
            REG_GAIN_I: prdata = DATA_W'(r_gain_i);
            REG_GAIN_D: prdata = DATA_W'(r_gain_d);
            REG_ILIMIT: prdata = DATA_W'(r_ilimit);
            default:    prdata = '0;
        endcase
    end

    // ---------------- target forming ----------------
    always_comb begin
        w_l_hi = r_in.sample_light;
        w_l_lo = r_in.sample_light;
        if (r_light_seen) begin
            w_l_hi = (r_in.sample_light > r_light_high) ? r_in.sample_light : r_light_high;
            w_l_lo = (r_in.sample_light < r_light_low) ? r_in.sample_light : r_light_low;
        end
    end

    assign w_slot    = ({1'b0, r_slot} < (SLOT_W+1)'(SOUND_TAPS)) ? r_slot : '0;
    assign w_slot_nx = (w_slot == SLOT_W'(SOUND_TAPS - 1)) ? '0 : w_slot + 1'b1;

    always_comb begin
        w_sum = '0;
        for (int i = 0; i < SOUND_TAPS; i++) begin
            w_taps[i] = (w_slot == SLOT_W'(i)) ? r_in.sample_sound : r_taps[i];
            w_sum     = w_sum + SUM_W'(w_taps[i]);
        end
    end

    always_comb begin
        w_s_hi = w_sum;
        w_s_lo = w_sum;
        if (r_sound_seen) begin
            w_s_hi = (w_sum > r_sound_high) ? w_sum : r_sound_high;
            w_s_lo = (w_sum < r_sound_low) ? w_sum : r_sound_low;
        end
    end

    // sweep step wraps at 16 bits, so an underflow lands on the top
    assign w_step    = (r_mode == MODE_FAST) ? IDX_W'(10) : IDX_W'(1);
    assign w_down    = (r_mode == MODE_FAST) ? r_fast_down : r_slow_down;
    assign w_sw_n    = w_down ? (r_sweep - w_step) : (r_sweep + w_step);
    assign w_sw_top  = (w_sw_n >= IDX_W'(SWEEP_TOP));
    assign w_sw_flip = w_sw_top || (w_sw_n == '0);
    assign w_sw_idx  = w_sw_top ? IDX_W'(SWEEP_TOP) : w_sw_n;

    always_comb begin
        unique case (r_mode)
            MODE_SOUND: begin
                w_map_x    = IDX_W'(w_sum - w_s_lo);
                w_map_k    = 4'd5;
                w_map_dsr  = DSR_W'(w_s_hi - w_s_lo);
                w_map_base = VOLT_8;
                w_map_skip = (w_s_hi <= w_s_lo);
            end
            MODE_MANUAL: begin
                w_map_x    = r_manual;
                w_map_k    = 4'd9;
                w_map_dsr  = MANUAL_DEN;
                w_map_base = VOLT_6;
                w_map_skip = 1'b0;
            end
            MODE_BREATH, MODE_FAST, MODE_BREATH_ALT: begin
                w_map_x    = w_sw_idx;
                w_map_k    = 4'd6;
                w_map_dsr  = DSR_W'(SWEEP_TOP);
                w_map_base = VOLT_6;
                w_map_skip = 1'b0;
            end
            default: begin
                w_map_x    = IDX_W'(r_in.sample_light - w_l_lo);
                w_map_k    = 4'd5;
                w_map_dsr  = DSR_W'(w_l_hi - w_l_lo);
                w_map_base = VOLT_8;
                w_map_skip = (w_l_hi <= w_l_lo);
            end
        endcase
    end

    assign w_vprod = VPROD_W'(r_in.sample_vout) * VPROD_W'(VOUT_NUM);

    // ---------------- pid ----------------
    assign w_err = $signed({1'b0, r_target}) - $signed({{(ERR_W-VOUT_W){1'b0}}, r_vout});
    assign w_lim = r_ilimit[CFG_W-1] ? $signed({1'b0, {ACC_W{1'b1}}} >> 1)
                                     : $signed({1'b0, r_ilimit, {FRAC_W{1'b0}}});
    assign w_isum = $signed({r_accum[ACC_W-1], r_accum})
                  + $signed({{(OPD_W-ERR_W){w_err[ERR_W-1]}}, w_err});

    always_comb begin
        priority if (w_isum > w_lim) begin
            w_iclamp = w_lim;
        end else if (w_isum < -w_lim) begin
            w_iclamp = -w_lim;
        end else begin
            w_iclamp = w_isum;
        end
    end

    assign w_integ = w_iclamp[ACC_W-1:0];
    assign w_deriv = $signed({w_err[ERR_W-1], w_err}) - $signed({r_prev_err[ERR_W-1], r_prev_err});

    always_comb begin
        priority if (r_psum < 0) begin
            w_duty = '0;
        end else if (r_psum >= $signed(PSUM_W'(DUTY_TOP) << DUTY_SH)) begin
            w_duty = DUTY_W'(DUTY_TOP);
        end else begin
            w_duty = r_psum[DUTY_SH +: DUTY_W];
        end
    end

    // ---------------- shared units ----------------
    always_comb begin
        w_div_req.start    = (r_state == S_PREP) ||
                             ((r_state == S_VDIV) && w_div_done && !r_tgt_skip);
        w_div_req.dividend = (r_state == S_PREP) ? DVD_W'(w_vprod) : r_tgt_dvd;
        w_div_req.divisor  = (r_state == S_PREP) ? VOUT_DEN : r_tgt_dsr;
    end

    always_comb begin
        w_mul_req.start   = (r_state == S_PID) ||
                            ((r_state == S_MUL) && w_mul_done && (r_term != TERM_D));
        w_mul_req.gain    = r_gain_p;
        w_mul_req.operand = {{(OPD_W-ERR_W){w_err[ERR_W-1]}}, w_err};
        if (r_state == S_MUL) begin
            if (r_term == TERM_P) begin
                w_mul_req.gain    = r_gain_i;
                w_mul_req.operand = {r_integ[ACC_W-1], r_integ};
            end else begin
                w_mul_req.gain    = r_gain_d;
                w_mul_req.operand = {{(OPD_W-ERR_W-1){r_deriv[ERR_W]}}, r_deriv};
            end
        end
    end

    mlvp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    mlvp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // ---------------- sequencer ----------------
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_light_seen <= 1'b0;
            r_light_high <= '0;
            r_light_low  <= '0;
            for (int i = 0; i < SOUND_TAPS; i++) begin
                r_taps[i] <= '0;
            end
            r_slot       <= '0;
            r_sound_seen <= 1'b0;
            r_sound_high <= '0;
            r_sound_low  <= '0;
            r_sweep      <= '0;
            r_slow_down  <= 1'b0;
            r_fast_down  <= 1'b0;
            r_prev_err   <= '0;
            r_accum      <= '0;
            r_term       <= TERM_P;
        end else begin
            // a new result replaces the one leaving in the same cycle
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_state <= S_VDIV;
                    unique case (r_mode)
                        MODE_SOUND: begin
                            for (int i = 0; i < SOUND_TAPS; i++) begin
                                r_taps[i] <= w_taps[i];
                            end
                            r_slot       <= w_slot_nx;
                            r_sound_seen <= 1'b1;
                            r_sound_high <= w_s_hi;
                            r_sound_low  <= w_s_lo;
                        end
                        MODE_MANUAL: ;
                        MODE_BREATH, MODE_BREATH_ALT: begin
                            r_sweep <= w_sw_idx;
                            if (w_sw_flip) begin
                                r_slow_down <= !r_slow_down;
                            end
                        end
                        MODE_FAST: begin
                            r_sweep <= w_sw_idx;
                            if (w_sw_flip) begin
                                r_fast_down <= !r_fast_down;
                            end
                        end
                        default: begin
                            r_light_seen <= 1'b1;
                            r_light_high <= w_l_hi;
                            r_light_low  <= w_l_lo;
                        end
                    endcase
                end
                S_VDIV: begin
                    if (w_div_done) begin
                        r_state <= r_tgt_skip ? S_PID : S_TDIV;
                    end
                end
                S_TDIV: begin
                    if (w_div_done) begin
                        r_state <= S_PID;
                    end
                end
                S_PID: begin
                    r_accum    <= w_integ;
                    r_prev_err <= w_err;
                    r_term     <= TERM_P;
                    r_state    <= S_MUL;
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        unique case (r_term)
                            TERM_P:  r_term <= TERM_I;
                            TERM_I:  r_term <= TERM_D;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // item payload registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_in <= i_in;
        end
        if (r_state == S_PREP) begin
            r_tgt_dvd  <= map_dvd(w_map_x, w_map_k);
            r_tgt_dsr  <= w_map_dsr;
            r_tgt_base <= w_map_base;
            r_tgt_skip <= w_map_skip;
        end
        if ((r_state == S_VDIV) && w_div_done) begin
            r_vout   <= w_quot[VOUT_W-1:0];
            r_target <= r_tgt_base;
        end
        if ((r_state == S_TDIV) && w_div_done) begin
            r_target <= r_tgt_base + w_quot[TGT_W-1:0];
        end
        if (r_state == S_PID) begin
            r_integ <= w_integ;
            r_deriv <= w_deriv;
            r_psum  <= '0;
        end
        if ((r_state == S_MUL) && w_mul_done) begin
            r_psum <= r_psum + $signed({{(PSUM_W-PROD_W){w_prod[PROD_W-1]}}, w_prod});
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out.duty         <= w_duty;
            r_out.target_volts <= r_target;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ hdl/mlvp_checker.sv @@
// port-level checks for the lamp voltage pid, bound to the top level
module mlvp_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input mlvp_pkg::t_out o_out,
    input logic           pready
);
    import mlvp_pkg::*;

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // saturation keeps the duty in range
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.duty <= DUTY_W'(DUTY_TOP)))
        else $error("duty above top");

    // one item in flight: input closes after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while busy");

    // no early result: o_out_valid does not rise at the sampled point after a fresh item is taken while none is shown
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> ##2 !$rose(o_out_valid))
        else $error("result too early");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind multimode_lamp_voltage_pid mlvp_checker u_mlvp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out),
    .pready      (pready)
);
